@@ hdl/weighted_adjacency_matrix_engine_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the weighted adjacency matrix engine
// Concurrent checks on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_ADJACENCY_MATRIX_ENGINE_TOP_ASSERT_SVH
`define WEIGHTED_ADJACENCY_MATRIX_ENGINE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define WAME_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WAME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define WAME_ASSERT_IMPL(lbl, ante, cons, msg)
`define WAME_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/wame_pkg.sv @@
// ---------------------------------------------------------------------------
// wame_pkg
// Shared types and constants of the weighted adjacency matrix engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wame_pkg;

	localparam int VTX_W  = 8;   // vertex index field
	localparam int WGT_W  = 16;  // stored edge weight
	localparam int VAL_W  = 32;  // result value
	localparam int CNT_W  = 9;   // active vertex count, up to 256
	localparam int VC_W   = 5;   // vertex_count register
	localparam int FND_W  = 5;   // listed neighbours, up to the limit

	localparam logic [FND_W-1:0] RESULT_LIMIT = 5'd16;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;

	typedef enum logic [2:0] {
		OP_SET   = 3'd0,
		OP_READ  = 3'd1,
		OP_PATH  = 3'd2,
		OP_SUCC  = 3'd3,
		OP_PRED  = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	// classified command word, front to back
	typedef struct packed {
		op_t              op;
		logic [VTX_W-1:0] a;
		logic [VTX_W-1:0] b;
		logic             a_ok;
		logic             b_ok;
		logic [WGT_W-1:0] weight;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [VTX_W-1:0] neighbour;
		logic             present;
		logic [1:0]       status;
		logic             final_item;
	} res_t;

endpackage

@@ hdl/wame_ram.sv @@
// ---------------------------------------------------------------------------
// wame_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wame_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/wame_front.sv @@
// ---------------------------------------------------------------------------
// wame_front
// Accepts input words, checks vertex ranges, drops unused operation codes
// and queues the commands for the execution side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wame_front
	import wame_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [2:0]       operation,
	input  logic [VTX_W-1:0] start_vertex,
	input  logic [VTX_W-1:0] end_vertex,
	input  logic [WGT_W-1:0] edge_weight,
	input  logic             path_end,
	input  logic [CNT_W-1:0] n_act,
	output logic             full,
	output cmd_t             cmd,
	output logic             cmd_vld,
	input  logic             pop
);

	cmd_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       do_push;
	logic       do_pop;
	cmd_t       nxt;

	always_comb begin
		unique case (op_t'(operation))
			OP_SET, OP_READ, OP_PATH, OP_SUCC, OP_PRED, OP_CLEAR: keep = 1'b1;
			default:                                              keep = 1'b0;
		endcase
		nxt.op     = op_t'(operation);
		nxt.a      = start_vertex;
		nxt.b      = end_vertex;
		nxt.a_ok   = CNT_W'(start_vertex) < n_act;
		nxt.b_ok   = CNT_W'(end_vertex) < n_act;
		nxt.weight = edge_weight;
		nxt.last   = path_end;
	end

	assign full    = cnt_q == 2'd2;
	assign cmd_vld = cnt_q != 2'd0;
	assign cmd     = q_q[rd_ptr_q];
	assign do_push = push && keep;
	assign do_pop  = pop && cmd_vld;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

@@ hdl/wame_back.sv @@
// ---------------------------------------------------------------------------
// wame_back
// Executes queued commands against the weight matrix RAM: edge writes and
// reads, path accumulation, row and column scans, and clearing sweeps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wame_back
	import wame_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_clear,
	input  logic [CNT_W-1:0] n_act,
	input  cmd_t             cmd,
	input  logic             cmd_vld,
	output logic             pop,
	output logic             init_busy,
	output res_t             res,
	output logic             res_vld
);

	localparam int IW    = $clog2(MAX_VERTICES);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT,
		S_SCAN,
		S_SWEEP
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [AW-1:0]     sweep_q;
	logic              sweep_emit_q;
	logic [IW:0]       j_q;
	logic [FND_W-1:0]  found_q;
	logic [IW-1:0]     hold_idx_q;
	logic [WGT_W-1:0]  hold_w_q;
	logic              rd_vld_s1;
	logic [IW-1:0]     rd_idx_s1;
	logic              started_q;
	logic              broken_q;
	logic [VAL_W-1:0]  total_q;
	logic [IW-1:0]     prev_q;
	logic              prev_ok_q;
	res_t              res_q;
	logic              res_vld_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [WGT_W-1:0]  wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [WGT_W-1:0]  rdata;
	logic              scan_issue;
	logic [IW-1:0]     a_idx;
	logic [IW-1:0]     b_idx;
	logic [IW-1:0]     j_idx;
	logic              rd_pos;
	logic [VAL_W-1:0]  sum_sat;

	function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] t, logic [WGT_W-1:0] w);
		logic [VAL_W:0] s;
		s = {t[VAL_W-1], t} + {{(VAL_W-WGT_W+1){w[WGT_W-1]}}, w};
		if (s[VAL_W] != s[VAL_W-1]) begin
			return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return s[VAL_W-1:0];
	endfunction

	function automatic res_t mk_res(logic [VAL_W-1:0] v, logic [VTX_W-1:0] nb, logic pr,
			logic [1:0] st, logic fin);
		res_t r;
		r.value      = v;
		r.neighbour  = nb;
		r.present    = pr;
		r.status     = st;
		r.final_item = fin;
		return r;
	endfunction

	assign a_idx   = cmd_q.a[IW-1:0];
	assign b_idx   = cmd_q.b[IW-1:0];
	assign j_idx   = j_q[IW-1:0];
	assign rd_pos  = !rdata[WGT_W-1] && (rdata != '0);
	assign sum_sat = sat_add(total_q, rdata);

	assign scan_issue = (state_q == S_SCAN) && (CNT_W'(j_q) < n_act)
		&& (found_q < RESULT_LIMIT);

	always_comb begin
		we    = 1'b0;
		waddr = {a_idx, b_idx};
		wdata = cmd_q.weight;
		re    = 1'b0;
		raddr = {a_idx, b_idx};
		if (state_q == S_SWEEP) begin
			we    = 1'b1;
			waddr = sweep_q;
			wdata = '0;
		end else if (state_q == S_EXEC) begin
			case (cmd_q.op)
				OP_SET:  we = cmd_q.a_ok && cmd_q.b_ok;
				OP_READ: re = cmd_q.a_ok && cmd_q.b_ok;
				OP_PATH: begin
					re    = started_q && !broken_q && cmd_q.a_ok && prev_ok_q;
					raddr = {prev_q, a_idx};
				end
				default: re = 1'b0;
			endcase
		end else if (state_q == S_SCAN) begin
			re    = scan_issue;
			raddr = (cmd_q.op == OP_SUCC) ? {a_idx, j_idx} : {j_idx, a_idx};
		end
	end

	wame_ram #(
		.WIDTH (WGT_W),
		.DEPTH (DEPTH)
	) u_matrix (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign pop       = (state_q == S_IDLE) && cmd_vld;
	assign init_busy = (state_q == S_SWEEP) && !sweep_emit_q;
	assign res       = res_q;
	assign res_vld   = res_vld_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end
		if (state_q == S_SCAN) begin
			rd_idx_s1 <= j_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_q      <= '0;
			sweep_emit_q <= 1'b0;
			j_q          <= '0;
			found_q      <= '0;
			hold_idx_q   <= '0;
			hold_w_q     <= '0;
			rd_vld_s1    <= 1'b0;
			started_q    <= 1'b0;
			broken_q     <= 1'b0;
			total_q      <= '0;
			prev_q       <= '0;
			prev_ok_q    <= 1'b0;
			res_q        <= '0;
			res_vld_q    <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			rd_vld_s1 <= scan_issue;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_vld) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					case (cmd_q.op)
						OP_SET: begin
							res_q     <= mk_res('0, '0, 1'b0,
								(cmd_q.a_ok && cmd_q.b_ok) ? ST_OK : ST_RANGE, 1'b1);
							res_vld_q <= 1'b1;
						end
						OP_READ: begin
							if (cmd_q.a_ok && cmd_q.b_ok) begin
								state_q <= S_WAIT;
							end else begin
								res_q     <= mk_res('0, '0, 1'b0, ST_RANGE, 1'b1);
								res_vld_q <= 1'b1;
							end
						end
						OP_PATH: begin
							if (started_q && !broken_q && cmd_q.a_ok && prev_ok_q) begin
								state_q <= S_WAIT;
							end else begin
								// opening vertex, a path already broken, or a hop with an out-of-range vertex
								broken_q  <= started_q;
								started_q <= 1'b1;
								if (!started_q) begin
									total_q <= '0;
								end
								prev_q    <= a_idx;
								prev_ok_q <= cmd_q.a_ok;
								if (cmd_q.last) begin
									res_q     <= mk_res('0, '0, 1'b0, ST_OK, 1'b1);
									res_vld_q <= 1'b1;
									started_q <= 1'b0;
									broken_q  <= 1'b0;
									total_q   <= '0;
									prev_q    <= '0;
									prev_ok_q <= 1'b0;
								end
							end
						end
						OP_SUCC, OP_PRED: begin
							if (cmd_q.a_ok) begin
								state_q <= S_SCAN;
								j_q     <= '0;
								found_q <= '0;
							end else begin
								res_q     <= mk_res('0, '0, 1'b0, ST_RANGE, 1'b1);
								res_vld_q <= 1'b1;
							end
						end
						OP_CLEAR: begin
							state_q      <= S_SWEEP;
							sweep_q      <= '0;
							sweep_emit_q <= 1'b1;
							started_q    <= 1'b0;
							broken_q     <= 1'b0;
							total_q      <= '0;
							prev_q       <= '0;
							prev_ok_q    <= 1'b0;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_WAIT: begin
					state_q <= S_IDLE;
					if (cmd_q.op == OP_READ) begin
						res_q     <= mk_res({{(VAL_W-WGT_W){rdata[WGT_W-1]}}, rdata}, '0,
							rdata != '0, ST_OK, 1'b1);
						res_vld_q <= 1'b1;
					end else begin
						if (rdata == '0) begin
							broken_q <= 1'b1;
						end else begin
							total_q <= sum_sat;
						end
						prev_q    <= a_idx;
						prev_ok_q <= cmd_q.a_ok;
						if (cmd_q.last) begin
							res_q     <= mk_res((rdata == '0) ? '0 : sum_sat, '0, 1'b0,
								ST_OK, 1'b1);
							res_vld_q <= 1'b1;
							started_q <= 1'b0;
							broken_q  <= 1'b0;
							total_q   <= '0;
							prev_q    <= '0;
							prev_ok_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						j_q <= j_q + 1'b1;
					end
					// one found entry is held back so the last one can carry final_item
					if (rd_vld_s1 && rd_pos && found_q < RESULT_LIMIT) begin
						if (found_q != '0) begin
							res_q     <= mk_res({{(VAL_W-WGT_W){1'b0}}, hold_w_q},
								VTX_W'(hold_idx_q), 1'b1, ST_OK, 1'b0);
							res_vld_q <= 1'b1;
						end
						hold_w_q   <= rdata;
						hold_idx_q <= rd_idx_s1;
						found_q    <= found_q + 1'b1;
					end
					if (!scan_issue && !rd_vld_s1) begin
						state_q   <= S_IDLE;
						res_vld_q <= 1'b1;
						if (found_q == '0) begin
							res_q <= mk_res('0, '0, 1'b0, ST_NONE, 1'b1);
						end else begin
							res_q <= mk_res({{(VAL_W-WGT_W){1'b0}}, hold_w_q},
								VTX_W'(hold_idx_q), 1'b1, ST_OK, 1'b1);
						end
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == {AW{1'b1}}) begin
						state_q <= S_IDLE;
						if (sweep_emit_q) begin
							res_q     <= mk_res('0, '0, 1'b0, ST_OK, 1'b1);
							res_vld_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// register write: restart the clearing pass, drop the path
			if (cfg_clear) begin
				state_q      <= S_SWEEP;
				sweep_q      <= '0;
				sweep_emit_q <= 1'b0;
				res_vld_q    <= 1'b0;
				started_q    <= 1'b0;
				broken_q     <= 1'b0;
				total_q      <= '0;
				prev_q       <= '0;
				prev_ok_q    <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/weighted_adjacency_matrix_engine_top.sv @@
// ---------------------------------------------------------------------------
// weighted_adjacency_matrix_engine_top
// Dense weighted directed graph engine with an APB register port.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low; it is checked and
// placed in a two-word queue, so up to two commands can wait while one runs.
// Results appear for one cycle each with result_valid high and cannot be
// held off; final_item marks the last result of a command. Operation codes
// six and seven are dropped at the input. After leaving the queue, a set
// edge is written directly, a weight read or path hop waits for the
// registered matrix read, and a successor or predecessor listing scans up to
// the n active vertices in turn through the single matrix read port. Clear
// sweeps all 4^ceil(log2 MAX_VERTICES) matrix RAM entries (256 at the
// default), one entry per cycle. After reset, the same sweep runs with
// busy high; writing vertex_count also starts it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "weighted_adjacency_matrix_engine_top_assert.svh"

module weighted_adjacency_matrix_engine_top
	import wame_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              operation,
	input  logic [VTX_W-1:0]        start_vertex,
	input  logic [VTX_W-1:0]        end_vertex,
	input  logic signed [WGT_W-1:0] edge_weight,
	input  logic                    path_end,
	output logic                    result_valid,
	output logic signed [VAL_W-1:0] value,
	output logic [VTX_W-1:0]        neighbour,
	output logic                    edge_present,
	output logic [1:0]              status,
	output logic                    final_item
);

	localparam logic             REG_VERTEX_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] MAX_N            = CNT_W'(MAX_VERTICES);

	logic [VC_W-1:0]  vc_q;
	logic [CNT_W-1:0] vc_ext;
	logic [CNT_W-1:0] n_act;
	logic             cfg_wr;
	logic             fifo_full;
	logic             init_busy;
	logic             accept;
	logic             pop;
	logic             cmd_vld;
	cmd_t             cmd;
	res_t             res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vc_q) : '0;

	assign vc_ext = CNT_W'(vc_q);
	assign n_act  = (vc_ext > MAX_N) ? MAX_N : vc_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= '0;
		end else if (cfg_wr) begin
			vc_q <= pwdata[VC_W-1:0];
		end
	end

	assign busy   = fifo_full || init_busy;
	assign accept = start && !busy;

	wame_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (accept),
		.operation    (operation),
		.start_vertex (start_vertex),
		.end_vertex   (end_vertex),
		.edge_weight  (edge_weight),
		.path_end     (path_end),
		.n_act        (n_act),
		.full         (fifo_full),
		.cmd          (cmd),
		.cmd_vld      (cmd_vld),
		.pop          (pop)
	);

	wame_back #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_clear (cfg_wr),
		.n_act     (n_act),
		.cmd       (cmd),
		.cmd_vld   (cmd_vld),
		.pop       (pop),
		.init_busy (init_busy),
		.res       (res),
		.res_vld   (result_valid)
	);

	assign value        = res.value;
	assign neighbour    = res.neighbour;
	assign edge_present = res.present;
	assign status       = res.status;
	assign final_item   = res.final_item;

	`WAME_ASSERT_IMPL(a_no_result_in_init, init_busy, !result_valid,
		"result during reset clearing pass")
	`WAME_ASSERT_IMPL(a_error_is_final, result_valid && (status != ST_OK),
		final_item && (value == '0) && !edge_present, "error result not final or not empty")
	`WAME_ASSERT_IMPL(a_present_nonzero, result_valid && edge_present, value != '0,
		"edge_present with zero value")
	`WAME_ASSERT_NEXT(a_cfg_quiet, cfg_wr, !result_valid,
		"result right after vertex_count write")

endmodule

@@ verif/wame_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wame_checker
// Watches the command, register and result channels of the adjacency matrix
// engine, keeps its own copy of the graph and path state, predicts the
// result words of every accepted command and compares them in order.
// ---------------------------------------------------------------------------

module wame_checker
	import wame_pkg::*;
#(
	parameter int         MAX_VERTICES = 16,
	parameter logic [2:0] VC_ADDR      = 3'd0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	input  logic                    pready,
	input  logic                    start,
	input  logic                    busy,
	input  logic [2:0]              operation,
	input  logic [VTX_W-1:0]        start_vertex,
	input  logic [VTX_W-1:0]        end_vertex,
	input  logic signed [WGT_W-1:0] edge_weight,
	input  logic                    path_end,
	input  logic                    result_valid,
	input  logic signed [VAL_W-1:0] value,
	input  logic [VTX_W-1:0]        neighbour,
	input  logic                    edge_present,
	input  logic [1:0]              status,
	input  logic                    final_item,
	output int                      mismatches,
	output int                      words_due
);

	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	logic signed [WGT_W-1:0] graph [MAX_VERTICES*MAX_VERTICES];
	logic [VC_W-1:0]         vtx_count;
	logic [VTX_W-1:0]        walk_prev;
	longint                  walk_sum;
	bit                      walk_open;
	bit                      walk_broken;
	res_t                    due_q[$];
	int                      err_cnt = 0;

	function automatic int live_count();
		return (vtx_count > MAX_VERTICES) ? MAX_VERTICES : int'(vtx_count);
	endfunction

	function automatic void drop_walk();
		walk_prev   = '0;
		walk_sum    = 0;
		walk_open   = 1'b0;
		walk_broken = 1'b0;
	endfunction

	function automatic void reset_graph();
		foreach (graph[i]) graph[i] = '0;
		drop_walk();
	endfunction

	function automatic void queue_word(logic signed [VAL_W-1:0] v, logic [VTX_W-1:0] nb,
			logic present, logic [1:0] st, logic fin);
		res_t r;
		r.value      = v;
		r.neighbour  = nb;
		r.present    = present;
		r.status     = st;
		r.final_item = fin;
		due_q.push_back(r);
	endfunction

	function automatic void predict_command(logic [2:0] opc, logic [VTX_W-1:0] a,
			logic [VTX_W-1:0] b, logic signed [WGT_W-1:0] w, logic last);
		int n;
		bit a_ok;
		bit b_ok;
		logic signed [WGT_W-1:0] cw;
		logic signed [WGT_W-1:0] hit_w[$];
		int hit_v[$];
		n = live_count();
		a_ok = a < n;
		b_ok = b < n;
		case (opc)
			OP_SET: begin
				if (a_ok && b_ok) begin
					graph[a*MAX_VERTICES + b] = w;
					queue_word('0, '0, 1'b0, ST_OK, 1'b1);
				end else begin
					queue_word('0, '0, 1'b0, ST_RANGE, 1'b1);
				end
			end
			OP_READ: begin
				if (a_ok && b_ok) begin
					cw = graph[a*MAX_VERTICES + b];
					queue_word(cw, '0, cw != 0, ST_OK, 1'b1);
				end else begin
					queue_word('0, '0, 1'b0, ST_RANGE, 1'b1);
				end
			end
			OP_PATH: begin
				if (!walk_open) begin
					walk_open   = 1'b1;
					walk_sum    = 0;
					walk_broken = 1'b0;
				end else if (!walk_broken) begin
					cw = '0;
					if (a_ok && walk_prev < n)
						cw = graph[walk_prev*MAX_VERTICES + a];
					if (cw == 0) begin
						walk_broken = 1'b1;
					end else begin
						// clamp after every hop, not only at the end
						walk_sum += cw;
						if (walk_sum > SUM_MAX) walk_sum = SUM_MAX;
						if (walk_sum < SUM_MIN) walk_sum = SUM_MIN;
					end
				end
				walk_prev = a;
				if (last) begin
					queue_word(walk_broken ? '0 : VAL_W'(walk_sum), '0, 1'b0, ST_OK, 1'b1);
					drop_walk();
				end
			end
			OP_SUCC, OP_PRED: begin
				if (!a_ok) begin
					queue_word('0, '0, 1'b0, ST_RANGE, 1'b1);
				end else begin
					for (int j = 0; j < n; j++) begin
						cw = (opc == OP_SUCC) ? graph[a*MAX_VERTICES + j]
							: graph[j*MAX_VERTICES + a];
						if (cw > 0 && hit_w.size() < RESULT_LIMIT) begin
							hit_w.push_back(cw);
							hit_v.push_back(j);
						end
					end
					if (hit_w.size() == 0)
						queue_word('0, '0, 1'b0, ST_NONE, 1'b1);
					foreach (hit_w[k])
						queue_word(hit_w[k], VTX_W'(hit_v[k]), 1'b1, ST_OK,
							k == hit_w.size() - 1);
				end
			end
			OP_CLEAR: begin
				reset_graph();
				queue_word('0, '0, 1'b0, ST_OK, 1'b1);
			end
			default: ;  // spare codes are dropped
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			vtx_count = '0;
			reset_graph();
			due_q.delete();
			err_cnt = 0;
			mismatches <= 0;
			words_due <= 0;
		end else begin
			// results first: a word taken at this edge cannot answer yet
			if (result_valid) begin
				if (due_q.size() == 0) begin
					$error("result word with nothing expected: value %0d neighbour %0d",
						value, neighbour);
					err_cnt++;
				end else begin
					want = due_q.pop_front();
					if (value !== want.value) begin
						$error("value: expected %0d, got %0d", $signed(want.value), value);
						err_cnt++;
					end
					if (neighbour !== want.neighbour) begin
						$error("neighbour: expected %0d, got %0d", want.neighbour, neighbour);
						err_cnt++;
					end
					if (edge_present !== want.present) begin
						$error("edge_present: expected %0d, got %0d", want.present,
							edge_present);
						err_cnt++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						err_cnt++;
					end
					if (final_item !== want.final_item) begin
						$error("final_item: expected %0d, got %0d", want.final_item,
							final_item);
						err_cnt++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == VC_ADDR) begin
				vtx_count = pwdata[VC_W-1:0];
				reset_graph();
			end
			if (start && !busy)
				predict_command(operation, start_vertex, end_vertex, edge_weight, path_end);
			mismatches <= err_cnt;
			words_due <= due_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives the adjacency matrix engine through several vertex counts: a
// directed pass over edge cases, then random command traffic built mostly
// from whole path sequences. Checking lives in wame_checker; this module
// makes stimulus and reports the verdict.
// ---------------------------------------------------------------------------

module tb;
	import wame_pkg::*;

	localparam int         MAX_VERTICES  = 16;
	localparam logic [2:0] VC_REG_ADDR   = 3'd0;
	localparam logic [2:0] OP_SPARE6     = 3'd6;
	localparam logic [2:0] OP_SPARE7     = 3'd7;
	localparam int         SETTLE_CYCLES = 300;  // covers a full clear sweep
	localparam int         IDLE_PCT      = 28;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    psel         = 1'b0;
	logic                    penable      = 1'b0;
	logic                    pwrite       = 1'b0;
	logic [2:0]              paddr        = '0;
	logic [31:0]             pwdata       = '0;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    start        = 1'b0;
	logic                    busy;
	logic [2:0]              operation    = '0;
	logic [VTX_W-1:0]        start_vertex = '0;
	logic [VTX_W-1:0]        end_vertex   = '0;
	logic signed [WGT_W-1:0] edge_weight  = '0;
	logic                    path_end     = 1'b0;
	logic                    result_valid;
	logic signed [VAL_W-1:0] value;
	logic [VTX_W-1:0]        neighbour;
	logic                    edge_present;
	logic [1:0]              status;
	logic                    final_item;
	int                      mismatches;
	int                      words_due;

	bit idle_on       = 1'b1;
	int live_vertices = 0;

	weighted_adjacency_matrix_engine_top #(.MAX_VERTICES(MAX_VERTICES)) dut (.*);

	wame_checker #(.MAX_VERTICES(MAX_VERTICES), .VC_ADDR(VC_REG_ADDR)) graph_check (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_word(logic [2:0] opc, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
			logic signed [WGT_W-1:0] w, logic last);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			start        <= 1'b0;
			operation    <= 3'($urandom());
			start_vertex <= 8'($urandom());
			end_vertex   <= 8'($urandom());
			edge_weight  <= 16'($urandom());
			path_end     <= 1'($urandom());
			@(posedge clk);
		end
		start        <= 1'b1;
		operation    <= opc;
		start_vertex <= a;
		end_vertex   <= b;
		edge_weight  <= w;
		path_end     <= last;
		do @(posedge clk); while (busy);
	endtask

	// wait for every expected word, then for any silent work to finish
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (words_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_vertex_count(logic [VC_W-1:0] vc);
		settle();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= VC_REG_ADDR;
		pwdata  <= {27'($urandom()), vc};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		live_vertices = (vc > MAX_VERTICES) ? MAX_VERTICES : int'(vc);
	endtask

	function automatic logic [VTX_W-1:0] pick_vertex();
		if (live_vertices == 0 || $urandom_range(0, 99) < 15)
			return 8'($urandom());
		return 8'($urandom_range(0, live_vertices - 1));
	endfunction

	function automatic logic signed [WGT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 16'sh7fff;
			2: return 16'sh8000;
			3, 4, 5: return 16'($urandom_range(1, 32767));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic directed_checks();
		send_word(OP_SET, 8'd0, 8'd15, 16'sh7fff, 1'b0);
		send_word(OP_SET, 8'd15, 8'd0, 16'sh8000, 1'b1);
		send_word(OP_SET, 8'd255, 8'd0, 16'sd9, 1'b0);
		send_word(OP_SET, 8'd0, 8'd255, -16'sd1, 1'b0);
		send_word(OP_READ, 8'd0, 8'd15, '0, 1'b0);
		send_word(OP_READ, 8'd15, 8'd0, 16'shffff, 1'b1);
		send_word(OP_READ, 8'd3, 8'd4, '0, 1'b0);
		send_word(OP_READ, 8'd16, 8'd0, '0, 1'b0);
		// 0 -> 15 -> 0 sums to -1
		send_word(OP_PATH, 8'd0, 8'd0, '0, 1'b0);
		send_word(OP_PATH, 8'd15, 8'd0, '0, 1'b0);
		send_word(OP_PATH, 8'd0, 8'd0, '0, 1'b1);
		send_word(OP_PATH, 8'd7, 8'd255, '0, 1'b1);
		// missing edge, then an out-of-range hop
		send_word(OP_PATH, 8'd3, 8'd0, '0, 1'b0);
		send_word(OP_PATH, 8'd4, 8'd0, '0, 1'b1);
		send_word(OP_PATH, 8'd0, 8'd0, '0, 1'b0);
		send_word(OP_PATH, 8'd200, 8'd0, '0, 1'b0);
		send_word(OP_PATH, 8'd15, 8'd0, '0, 1'b1);
		send_word(OP_SUCC, 8'd0, 8'd0, '0, 1'b0);
		send_word(OP_PRED, 8'd0, 8'd0, '0, 1'b0);  // only a negative weight in column
		send_word(OP_SUCC, 8'd255, 8'd0, '0, 1'b0);
		send_word(OP_PRED, 8'd16, 8'd0, '0, 1'b0);
		send_word(OP_SPARE6, 8'd0, 8'd0, '0, 1'b0);
		send_word(OP_SPARE7, 8'd255, 8'd255, 16'shffff, 1'b1);
		send_word(OP_SET, 8'd0, 8'd15, '0, 1'b0);
		send_word(OP_READ, 8'd0, 8'd15, '0, 1'b0);
		send_word(OP_CLEAR, 8'd0, 8'd0, '0, 1'b0);
		send_word(OP_READ, 8'd15, 8'd0, '0, 1'b0);
		// fill a whole row so the listing hits its word limit
		for (int j = 0; j < MAX_VERTICES; j++)
			send_word(OP_SET, 8'd0, 8'(j), 16'(j + 1), 1'b0);
		send_word(OP_SUCC, 8'd0, 8'd0, '0, 1'b0);
		send_word(OP_PRED, 8'd5, 8'd0, '0, 1'b0);
	endtask

	task automatic random_traffic(int budget);
		int sent;
		int len;
		bit whole;
		logic [VTX_W-1:0] hops[$];
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(0, 19))
				0: begin
					send_word(OP_CLEAR, pick_vertex(), pick_vertex(), pick_weight(),
						1'($urandom()));
					sent++;
				end
				1: send_word($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, pick_vertex(),
						pick_vertex(), pick_weight(), 1'($urandom()));
				2: begin
					// stray hop, may land in the middle of a path
					send_word(OP_PATH, pick_vertex(), pick_vertex(), pick_weight(),
						1'($urandom()));
					sent++;
				end
				3, 4, 5, 6, 7: begin
					len = $urandom_range(2, 5);
					whole = $urandom_range(0, 4) != 0;
					hops.delete();
					for (int k = 0; k < len; k++)
						hops.push_back(live_vertices == 0 ? 8'($urandom())
							: 8'($urandom_range(0, live_vertices - 1)));
					for (int k = 0; k < len - 1; k++)
						if (whole || $urandom_range(0, 2) != 0) begin
							send_word(OP_SET, hops[k], hops[k+1],
								16'($urandom_range(1, 65535)), 1'($urandom()));
							sent++;
						end
					for (int k = 0; k < len; k++) begin
						send_word(OP_PATH,
							(!whole && $urandom_range(0, 3) == 0) ? pick_vertex() : hops[k],
							8'($urandom()), 16'($urandom()), k == len - 1);
						sent++;
					end
				end
				8, 9, 10, 11: begin
					send_word(OP_SET, pick_vertex(), pick_vertex(), pick_weight(),
						1'($urandom()));
					sent++;
				end
				12, 13, 14: begin
					send_word(OP_READ, pick_vertex(), pick_vertex(), pick_weight(),
						1'($urandom()));
					sent++;
				end
				default: begin
					send_word($urandom_range(0, 1) ? OP_SUCC : OP_PRED, pick_vertex(),
						pick_vertex(), pick_weight(), 1'($urandom()));
					sent++;
				end
			endcase
		end
	endtask

	initial begin
		logic [VC_W-1:0] vc_plan [6];
		vc_plan = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd5, 5'd0};
		vc_plan[5] = 5'($urandom_range(2, 15));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (vc_plan[p]) begin
			write_vertex_count(vc_plan[p]);
			if (p == 0) begin
				// directed pass runs back to back, no idle cycles
				idle_on = 1'b0;
				directed_checks();
				idle_on = 1'b1;
			end
			random_traffic(9);
		end
		settle();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
